// ----- rtl/epoch_seconds_to_calendar_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// same-cycle implication
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg
// Types and constants shared by the epoch-to-calendar controller and datapath.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned ACC_W   = 32;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned CNT_W   = 1;
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [ACC_W-1:0] DAY_SECS   = 32'd86400;
  localparam logic [ACC_W-1:0] HOUR_SECS  = 32'd3600;
  localparam logic [ACC_W-1:0] MIN_SECS   = 32'd60;
  localparam logic [ACC_W-1:0] QUAD_DAYS  = 32'd1461;
  localparam logic [ACC_W-1:0] YEAR_DAYS  = 32'd365;
  localparam logic [ACC_W-1:0] QUAD_PHASE = 32'd671;
  localparam logic [7:0]       YEAR_BASE  = 8'd70;
  localparam logic [15:0]      WDAY_EPOCH = 16'd4;
  localparam logic [32:0]      LAST_VALID_SECOND = 33'd4102444799;

  // each pass: a quotient step, then a remainder step
  localparam logic [CNT_W-1:0] PASS_LAST = 1'b1;

  // quotient = ((x >> PRE) * RECIP) >> K; K is operand bits plus divisor bits,
  // which keeps the quotient exact over the whole operand range
  localparam int unsigned DAY_PRE  = 7;
  localparam int unsigned HOUR_PRE = 4;
  localparam int unsigned MIN_PRE  = 2;
  localparam int unsigned DAY_K    = 35;  // 25-bit operand, divisor 675
  localparam int unsigned HOUR_K   = 21;  // 13-bit operand, divisor 225
  localparam int unsigned MIN_K    = 14;  // 10-bit operand, divisor 15
  localparam int unsigned QUAD_K   = 27;  // 16-bit operand, divisor 1461
  localparam int unsigned YEAR_K   = 25;  // 16-bit operand, divisor 365

  localparam logic [MUL_B_W-1:0] DAY_RECIP =
    MUL_B_W'((64'd1 << DAY_K) / 64'(DAY_SECS >> DAY_PRE) + 64'd1);
  localparam logic [MUL_B_W-1:0] HOUR_RECIP =
    MUL_B_W'((64'd1 << HOUR_K) / 64'(HOUR_SECS >> HOUR_PRE) + 64'd1);
  localparam logic [MUL_B_W-1:0] MIN_RECIP =
    MUL_B_W'((64'd1 << MIN_K) / 64'(MIN_SECS >> MIN_PRE) + 64'd1);
  localparam logic [MUL_B_W-1:0] QUAD_RECIP =
    MUL_B_W'((64'd1 << QUAD_K) / 64'(QUAD_DAYS) + 64'd1);
  localparam logic [MUL_B_W-1:0] YEAR_RECIP =
    MUL_B_W'((64'd1 << YEAR_K) / 64'(YEAR_DAYS) + 64'd1);

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef enum logic [2:0] {
    PH_DAY  = 3'd0,
    PH_HOUR = 3'd1,
    PH_MIN  = 3'd2,
    PH_QUAD = 3'd3,
    PH_YEAR = 3'd4
  } phase_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic        mode;
  } req_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] year_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic       range_error;
  } res_t;

  typedef struct packed {
    logic   capture;
    logic   load;
    logic   step;
    logic   last;
    phase_t phase;
    logic   cal_a;
    logic   cal_b;
  } dp_cmd_t;

  typedef struct packed {
    logic range_err;
  } dp_status_t;

endpackage

// ----- rtl/esc_datapath.sv -----
// ----------------------------------------------------------------------------
// esc_datapath
// Offset add, range check, shared reciprocal-multiply divider and calendar
// lookup. Driven step by step by esc_ctrl.
// ----------------------------------------------------------------------------
module esc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  esc_pkg::dp_cmd_t    cmd,
  input  esc_pkg::req_t       request,
  input  logic                cfg_we,
  input  logic signed [10:0]  cfg_data,
  output esc_pkg::dp_status_t status,
  output esc_pkg::res_t       result
);
  import esc_pkg::*;

  function automatic logic [ACC_W-1:0] divisor(input phase_t ph);
    logic [ACC_W-1:0] base;
    begin
      case (ph)
        PH_DAY:  base = DAY_SECS;
        PH_HOUR: base = HOUR_SECS;
        PH_MIN:  base = MIN_SECS;
        PH_QUAD: base = QUAD_DAYS;
        PH_YEAR: base = YEAR_DAYS;
        default: base = DAY_SECS;
      endcase
      return base;
    end
  endfunction

  // mod 7 via octal digit sums (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [15:0] v);
    logic [5:0] s;
    logic [3:0] t;
    begin
      s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) + 6'(v[15]);
      t = 4'(s[2:0]) + 4'(s[5:3]);
      if (t >= 4'd7) begin
        t = t - 4'd7;
      end
      return t[2:0];
    end
  endfunction

  logic signed [10:0] tz;
  req_t               req;
  logic               err;
  logic [ACC_W-1:0]   acc;
  logic [Q_W-1:0]     q;
  logic [15:0]        days;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic [5:0]         q1;
  logic [7:0]         years;
  logic [8:0]         yrem;
  logic [8:0]         yday;
  logic               leap;
  logic [2:0]         wday;
  logic [3:0]         month;
  logic [4:0]         dom;

  logic signed [17:0] tz_ext;
  logic signed [17:0] off;
  logic signed [33:0] adj;
  logic               adj_err;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     quo;
  logic [ACC_W-1:0]   rem_new;
  logic [3:0]         mon_c;
  logic [8:0]         mstart;
  logic [9:0]         yday_c;

  always_comb begin
    tz_ext  = 18'(tz);
    off     = (tz_ext <<< 6) - (tz_ext <<< 2);
    adj     = $signed({2'b00, req.epoch_seconds}) + (req.mode ? 34'(off) : 34'sd0);
    adj_err = adj[33] || (adj[32:0] > LAST_VALID_SECOND);
    status.range_err = adj_err;

    mul_a = MUL_A_W'(acc);
    mul_b = DAY_RECIP;
    case (cmd.phase)
      PH_DAY: begin
        mul_a = MUL_A_W'(acc >> DAY_PRE);
        mul_b = DAY_RECIP;
      end
      PH_HOUR: begin
        mul_a = MUL_A_W'(acc >> HOUR_PRE);
        mul_b = HOUR_RECIP;
      end
      PH_MIN: begin
        mul_a = MUL_A_W'(acc >> MIN_PRE);
        mul_b = MIN_RECIP;
      end
      PH_QUAD: begin
        mul_b = QUAD_RECIP;
      end
      PH_YEAR: begin
        mul_b = YEAR_RECIP;
      end
      default: begin
        mul_b = DAY_RECIP;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    case (cmd.phase)
      PH_DAY:  quo = Q_W'(prod >> DAY_K);
      PH_HOUR: quo = Q_W'(prod >> HOUR_K);
      PH_MIN:  quo = Q_W'(prod >> MIN_K);
      PH_QUAD: quo = Q_W'(prod >> QUAD_K);
      PH_YEAR: quo = Q_W'(prod >> YEAR_K);
      default: quo = '0;
    endcase

    rem_new = acc - ACC_W'(q) * divisor(cmd.phase);

    yday_c  = 10'(yrem) + 10'(q1) - 10'((9'(years) + 9'd1) >> 2);

    mon_c = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (yday >= MONTH_START[m] + 9'((leap && m >= 2) ? 1 : 0)) begin
        mon_c = mon_c + 4'd1;
      end
    end
    mstart = MONTH_START[mon_c] + 9'((leap && mon_c >= 4'd2) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tz <= '0;
    end else if (cfg_we) begin
      tz <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
    if (cmd.load) begin
      err <= adj_err;
      acc <= adj[ACC_W-1:0];
      q   <= '0;
    end
    if (cmd.step) begin
      if (!cmd.last) begin
        q <= quo;
      end else begin
        case (cmd.phase)
          PH_DAY: begin
            days <= q;
            acc  <= rem_new;
          end
          PH_HOUR: begin
            hour <= q[4:0];
            acc  <= rem_new;
          end
          PH_MIN: begin
            minute <= q[5:0];
            second <= rem_new[5:0];
            acc    <= ACC_W'(days) + QUAD_PHASE;
          end
          PH_QUAD: begin
            q1  <= q[5:0];
            acc <= ACC_W'(days) - ACC_W'(q);
          end
          PH_YEAR: begin
            years <= q[7:0];
            yrem  <= rem_new[8:0];
          end
          default: begin
            acc <= rem_new;
          end
        endcase
      end
    end
    if (cmd.cal_a) begin
      yday <= yday_c[8:0];
      leap <= (years[1:0] == 2'd2);
      wday <= mod7(days + WDAY_EPOCH);
    end
    if (cmd.cal_b) begin
      month <= mon_c;
      dom   <= 5'(yday - mstart + 9'd1);
    end
  end

  always_comb begin
    result = '0;
    result.range_error = err;
    if (!err) begin
      result.second          = second;
      result.minute          = minute;
      result.hour            = hour;
      result.day_of_month    = dom;
      result.month           = month;
      result.year_since_1900 = years + YEAR_BASE;
      result.weekday         = wday;
      result.day_of_year     = yday;
    end
  end

endmodule

// ----- rtl/esc_ctrl.sv -----
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: accept, load and check, five division passes, calendar lookup,
// result strobe; a range error goes from load and check straight to the strobe.
// ----------------------------------------------------------------------------
module esc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  esc_pkg::dp_status_t status,
  output esc_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import esc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_DAY   = 10'b0000000100,
    S_HOUR  = 10'b0000001000,
    S_MIN   = 10'b0000010000,
    S_QUAD  = 10'b0000100000,
    S_YEAR  = 10'b0001000000,
    S_CAL_A = 10'b0010000000,
    S_CAL_B = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             cnt_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cnt_zero   = (cnt == '0);
    cmd        = '0;
    cmd.phase  = PH_DAY;
    cmd.last   = cnt_zero;
    state_next = state;
    cnt_next   = cnt_zero ? cnt : cnt - 1'b1;
    case (state)
      S_IDLE: begin
        cmd.capture = start;
        if (start) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        cnt_next = PASS_LAST;
        state_next = status.range_err ? S_DONE : S_DAY;
      end
      S_DAY: begin
        cmd.step  = 1'b1;
        cmd.phase = PH_DAY;
        if (cnt_zero) begin
          cnt_next   = PASS_LAST;
          state_next = S_HOUR;
        end
      end
      S_HOUR: begin
        cmd.step  = 1'b1;
        cmd.phase = PH_HOUR;
        if (cnt_zero) begin
          cnt_next   = PASS_LAST;
          state_next = S_MIN;
        end
      end
      S_MIN: begin
        cmd.step  = 1'b1;
        cmd.phase = PH_MIN;
        if (cnt_zero) begin
          cnt_next   = PASS_LAST;
          state_next = S_QUAD;
        end
      end
      S_QUAD: begin
        cmd.step  = 1'b1;
        cmd.phase = PH_QUAD;
        if (cnt_zero) begin
          cnt_next   = PASS_LAST;
          state_next = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd.step  = 1'b1;
        cmd.phase = PH_YEAR;
        if (cnt_zero) begin
          state_next = S_CAL_A;
        end
      end
      S_CAL_A: begin
        cmd.cal_a  = 1'b1;
        state_next = S_CAL_B;
      end
      S_CAL_B: begin
        cmd.cal_b  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ----- rtl/epoch_seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Seconds since 1970-01-01 to broken-down calendar time, optional zone offset.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------
//  input    | start, busy               | request (req_t)
//  result   | done (one-cycle strobe)   | result (res_t)
//  config   | cfg_valid, cfg_ready      | cfg_data (zone offset)
//
//  From accept to done strobe: load and check, five divisions by constants
//  (reciprocal multiply for the quotient, multiply-subtract for the remainder),
//  calendar lookup (states CAL_A, CAL_B) and the strobe; a time out of span
//  goes from load and check straight to the strobe.
//  One item at a time: busy stays high up to and including the cycle of done.
//  Synchronous reset clears the sequencer and offset; no receiver stall, cfg_ready high.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  esc_pkg::req_t      request,
  output logic               done,
  output esc_pkg::res_t      result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [10:0] cfg_data
);
  import esc_pkg::*;

  `include "epoch_seconds_to_calendar_assert.svh"

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       year_ok;
  logic       date_ok;

  assign cfg_ready = 1'b1;

  esc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  esc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .request  (request),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .status   (status),
    .result   (result)
  );

  assign year_ok = (result.year_since_1900 >= 8'd70) && (result.year_since_1900 <= 8'd199);
  assign date_ok = (result.month <= 4'd11) && (result.day_of_month != 5'd0) &&
                   (result.weekday <= 3'd6);

  `ESC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `ESC_ASSERT_NEXT(a_done_idle, done, !busy, "still busy after result")
  `ESC_ASSERT_NOW(a_year_span, done && !result.range_error, year_ok, "year out of span")
  `ESC_ASSERT_NOW(a_date_sane, done && !result.range_error, date_ok, "bad date fields")

endmodule
